// ===== hw/rtl/tehm_pkg.sv =====
`default_nettype none

package tehm_pkg;

    localparam int MODE_W  = 2;
    localparam int TIME_W  = 32;
    localparam int FREQ_W  = 24;
    localparam int MS_W    = 48;
    localparam int RPM_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int POLE_W  = 8;
    localparam int SEC_W   = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;

    // gain * 60 fits in 30 bits; (gain*60*freq) >> 24 also fits in 30 bits
    localparam int G60_W   = GAIN_W + 6;
    localparam int QUO_W   = G60_W;
    localparam int DV_W    = MS_W;
    localparam int DV_REM_W = 10;

    localparam logic [DV_REM_W:0] K_MS_PER_S = 11'd1000;
    localparam logic [TIME_W:0]   K_HALF_MS  = 33'd500;

    localparam logic [GAIN_W-1:0] RST_RPM_GAIN      = 24'd65536;
    localparam logic [POLE_W-1:0] RST_POLE_COUNT    = 8'd12;
    localparam logic [RPM_W-1:0]  RST_RPM_THRESHOLD = 16'd200;
    localparam logic [TIME_W-1:0] RST_RPM_PERIOD    = 32'd1000000;
    localparam logic [TIME_W-1:0] RST_HOURS_PERIOD  = 32'd2000000;
    localparam logic [TIME_W-1:0] RST_SAVE_PERIOD   = 32'd60000000;
    localparam logic [TIME_W-1:0] RST_FLUSH_MIN     = 32'd5000;

    typedef enum logic [MODE_W-1:0] {
        MODE_POLL  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_RPM_GAIN      = 3'd0,
        REG_POLE_COUNT    = 3'd1,
        REG_RPM_THRESHOLD = 3'd2,
        REG_RPM_PERIOD    = 3'd3,
        REG_HOURS_PERIOD  = 3'd4,
        REG_SAVE_PERIOD   = 3'd5,
        REG_FLUSH_MIN     = 3'd6
    } reg_idx_t;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_MODE = 12'b0000_0000_0010,
        S_CHK  = 12'b0000_0000_0100,
        S_MUL  = 12'b0000_0000_1000,
        S_DIV  = 12'b0000_0001_0000,
        S_UPD1 = 12'b0000_0010_0000,
        S_UPD2 = 12'b0000_0100_0000,
        S_ADD  = 12'b0000_1000_0000,
        S_SAVE = 12'b0001_0000_0000,
        S_HRS  = 12'b0010_0000_0000,
        S_HDIV = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tehm_if.sv =====
`default_nettype none

interface tehm_poll_if;
    import tehm_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [TIME_W-1:0]   now_us;
    logic [FREQ_W-1:0]   freq_hz;
    logic                freq_valid;
    logic [MS_W-1:0]     stored_ms;

    modport source (output valid, mode, now_us, freq_hz, freq_valid, stored_ms,
                    input ready);
    modport sink   (input valid, mode, now_us, freq_hz, freq_valid, stored_ms,
                    output ready);
endinterface

interface tehm_result_if;
    import tehm_pkg::*;

    logic                valid;
    logic                ready;
    logic [RPM_W-1:0]    rpm;
    logic [MS_W-1:0]     engine_time_ms;
    logic                rpm_report;
    logic                hours_report;
    logic [SEC_W-1:0]    hours_seconds;
    logic                save_request;
    logic [MS_W-1:0]     save_value_ms;

    modport source (output valid, rpm, engine_time_ms, rpm_report, hours_report,
                    hours_seconds, save_request, save_value_ms,
                    input ready);
    modport sink   (input valid, rpm, engine_time_ms, rpm_report, hours_report,
                    hours_seconds, save_request, save_value_ms,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tachometer_engine_hour_meter_top.sv =====
// channel  | dir | handshake      | payload
// ---------+-----+----------------+------------------------------------------------
// poll     | in  | valid/ready    | mode, now_us, freq_hz, freq_valid, stored_ms
// result   | out | valid/ready    | rpm, engine_time_ms, rpm/hours flags, seconds, save
// apb      | in  | psel/penable   | seven config registers at byte address 4*i
//
// Start, stop and a disabled poll go from idle via the mode state to output; a poll also checks
// the rpm and hours periods. An rpm update runs a 24-step shift-add multiplier over freq_hz,
// then a 30-step restoring divider by pole_count; a divide-by-1000 unit runs alongside. With
// the engine on, an add and a save check follow. An hours report waits for a 48-step pass of
// that unit. A new request is taken only in idle; the result register holds a finished result
// while the next request is worked on. Async active-low reset resets control state and config.
`default_nettype none

module tachometer_engine_hour_meter_top (
    input  wire                        clk,
    input  wire                        rst_n,
    tehm_poll_if.sink                  poll,
    tehm_result_if.source              result,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [tehm_pkg::ADDR_W-1:0] paddr,
    input  wire [tehm_pkg::DATA_W-1:0] pwdata,
    output logic [tehm_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import tehm_pkg::*;

    localparam logic [4:0] MUL_STEPS = 5'(FREQ_W);
    localparam logic [4:0] DIV_STEPS = 5'(QUO_W);
    localparam logic [5:0] DV_STEPS  = 6'(DV_W);

    // configuration
    logic [GAIN_W-1:0] rpm_gain_reg;
    logic [POLE_W-1:0] pole_count_reg;
    logic [RPM_W-1:0]  rpm_threshold_reg;
    logic [TIME_W-1:0] rpm_period_reg;
    logic [TIME_W-1:0] hours_period_reg;
    logic [TIME_W-1:0] save_period_reg;
    logic [TIME_W-1:0] flush_min_reg;

    // block state
    state_t            state_reg;
    logic              enabled_reg;
    logic              on_prev_reg;
    logic [MS_W-1:0]   engine_ms_reg;
    logic [MS_W-1:0]   persisted_reg;
    logic [TIME_W-1:0] last_rpm_time_reg;
    logic [TIME_W-1:0] last_hours_time_reg;
    logic [TIME_W-1:0] last_save_time_reg;
    logic [RPM_W-1:0]  last_rpm_reg;

    // latched request
    logic [MODE_W-1:0] mode_reg;
    logic [TIME_W-1:0] now_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [MS_W-1:0]   stored_reg;

    // per-request results
    logic              rpm_rep_reg;
    logic              hrs_rep_reg;
    logic [SEC_W-1:0]  hrs_sec_reg;
    logic              save_req_reg;
    logic [MS_W-1:0]   save_val_reg;
    logic [RPM_W-1:0]  rpm_val_reg;
    logic              on_reg;

    // rpm datapath: multiplier then divider, sharing the quotient register
    logic [G60_W-1:0]  g60_reg;
    logic [QUO_W-1:0]  mh_reg;
    logic [FREQ_W-1:0] ml_reg;
    logic [POLE_W-1:0] rr_reg;
    logic [4:0]        seq_cnt_reg;

    // shared divide-by-1000 unit
    logic [DV_W-1:0]     dv_q_reg;
    logic [DV_REM_W-1:0] dv_r_reg;
    logic [5:0]          dv_cnt_reg;

    // output register
    logic              out_valid_reg;
    logic [RPM_W-1:0]  out_rpm_reg;
    logic [MS_W-1:0]   out_engine_reg;
    logic              out_rpm_rep_reg;
    logic              out_hrs_rep_reg;
    logic [SEC_W-1:0]  out_hrs_sec_reg;
    logic              out_save_req_reg;
    logic [MS_W-1:0]   out_save_val_reg;

    function automatic logic period_due(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] last,
                                        input logic [TIME_W-1:0] period);
        logic [TIME_W-1:0] el;
        el = now - last;
        return (el >= period) && (el != '0);
    endfunction

    logic [TIME_W-1:0]   rpm_el_next;
    logic [G60_W-1:0]    g60_next;
    logic [POLE_W-1:0]   poles_next;
    logic [QUO_W:0]      mul_sum_next;
    logic [POLE_W:0]     rt_next;
    logic                rge_next;
    logic [POLE_W:0]     rsub_next;
    logic [DV_REM_W:0]   dt_next;
    logic                dge_next;
    logic [DV_REM_W:0]   dsub_next;
    logic [MS_W:0]       diff_next;
    logic [MS_W:0]       add_next;
    logic [RPM_W-1:0]    rpm_sat_next;
    logic                flush_ok_next;
    logic                stop_flush_next;
    logic                out_load;
    logic [2:0]          cfg_idx;
    logic                cfg_wr;

    assign rpm_el_next  = now_reg - last_rpm_time_reg;
    assign g60_next     = {rpm_gain_reg, 6'b0} - {4'b0, rpm_gain_reg, 2'b0};
    assign poles_next   = (pole_count_reg == '0) ? POLE_W'(1) : pole_count_reg;
    assign mul_sum_next = {1'b0, mh_reg} + {1'b0, (ml_reg[0] ? g60_reg : G60_W'(0))};
    assign rt_next      = {rr_reg, mh_reg[QUO_W-1]};
    assign rge_next     = rt_next >= {1'b0, poles_next};
    assign rsub_next    = rt_next - {1'b0, poles_next};
    assign dt_next      = {dv_r_reg, dv_q_reg[DV_W-1]};
    assign dge_next     = dt_next >= K_MS_PER_S;
    assign dsub_next    = dt_next - K_MS_PER_S;
    assign diff_next    = {1'b0, engine_ms_reg} - {1'b0, persisted_reg};
    // rounded milliseconds are below 2^23
    assign add_next     = {1'b0, engine_ms_reg} + {26'b0, dv_q_reg[22:0]};
    assign rpm_sat_next = (|mh_reg[QUO_W-1:RPM_W]) ? '1 : mh_reg[RPM_W-1:0];
    assign flush_ok_next = !diff_next[MS_W] && (diff_next[MS_W-1:0] != '0)
                           && (diff_next[MS_W-1:0] >= {16'b0, flush_min_reg});
    assign stop_flush_next = (stored_reg == persisted_reg) && !diff_next[MS_W]
                             && (diff_next[MS_W-1:0] != '0);

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    // config port
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        case (cfg_idx)
            REG_RPM_GAIN:      prdata = {8'b0, rpm_gain_reg};
            REG_POLE_COUNT:    prdata = {24'b0, pole_count_reg};
            REG_RPM_THRESHOLD: prdata = {16'b0, rpm_threshold_reg};
            REG_RPM_PERIOD:    prdata = rpm_period_reg;
            REG_HOURS_PERIOD:  prdata = hours_period_reg;
            REG_SAVE_PERIOD:   prdata = save_period_reg;
            REG_FLUSH_MIN:     prdata = flush_min_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_gain_reg      <= RST_RPM_GAIN;
            pole_count_reg    <= RST_POLE_COUNT;
            rpm_threshold_reg <= RST_RPM_THRESHOLD;
            rpm_period_reg    <= RST_RPM_PERIOD;
            hours_period_reg  <= RST_HOURS_PERIOD;
            save_period_reg   <= RST_SAVE_PERIOD;
            flush_min_reg     <= RST_FLUSH_MIN;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_RPM_GAIN:      rpm_gain_reg      <= pwdata[GAIN_W-1:0];
                REG_POLE_COUNT:    pole_count_reg    <= pwdata[POLE_W-1:0];
                REG_RPM_THRESHOLD: rpm_threshold_reg <= pwdata[RPM_W-1:0];
                REG_RPM_PERIOD:    rpm_period_reg    <= pwdata;
                REG_HOURS_PERIOD:  hours_period_reg  <= pwdata;
                REG_SAVE_PERIOD:   save_period_reg   <= pwdata;
                REG_FLUSH_MIN:     flush_min_reg     <= pwdata;
                default:           ;
            endcase
        end
    end

    // divide-by-1000 unit, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_cnt_reg <= '0;
        end
        else if (state_reg == S_CHK && period_due(now_reg, last_rpm_time_reg,
                                                  rpm_period_reg))
        begin
            dv_q_reg   <= {15'b0, {1'b0, rpm_el_next} + K_HALF_MS};
            dv_r_reg   <= '0;
            dv_cnt_reg <= DV_STEPS;
        end
        else if (state_reg == S_HRS && period_due(now_reg, last_hours_time_reg,
                                                  hours_period_reg))
        begin
            dv_q_reg   <= engine_ms_reg;
            dv_r_reg   <= '0;
            dv_cnt_reg <= DV_STEPS;
        end
        else if (dv_cnt_reg != '0)
        begin
            dv_r_reg   <= dge_next ? dsub_next[DV_REM_W-1:0] : dt_next[DV_REM_W-1:0];
            dv_q_reg   <= {dv_q_reg[DV_W-2:0], dge_next};
            dv_cnt_reg <= dv_cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            enabled_reg         <= 1'b0;
            on_prev_reg         <= 1'b0;
            engine_ms_reg       <= '0;
            persisted_reg       <= '0;
            last_rpm_time_reg   <= '0;
            last_hours_time_reg <= '0;
            last_save_time_reg  <= '0;
            last_rpm_reg        <= '0;
            seq_cnt_reg         <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (poll.valid)
                    begin
                        mode_reg     <= poll.mode;
                        now_reg      <= poll.now_us;
                        freq_reg     <= poll.freq_valid ? poll.freq_hz : '0;
                        stored_reg   <= poll.stored_ms;
                        rpm_rep_reg  <= 1'b0;
                        hrs_rep_reg  <= 1'b0;
                        hrs_sec_reg  <= '0;
                        save_req_reg <= 1'b0;
                        save_val_reg <= '0;
                        state_reg    <= S_MODE;
                    end
                end
                S_MODE:
                begin
                    case (mode_reg)
                        MODE_START:
                        begin
                            if (!enabled_reg)
                            begin
                                engine_ms_reg <= stored_reg;
                                persisted_reg <= stored_reg;
                                last_rpm_reg  <= '0;
                                enabled_reg   <= 1'b1;
                            end
                            state_reg <= S_OUT;
                        end
                        MODE_STOP:
                        begin
                            if (enabled_reg)
                            begin
                                if (stop_flush_next)
                                begin
                                    persisted_reg <= engine_ms_reg;
                                    save_req_reg  <= 1'b1;
                                    save_val_reg  <= engine_ms_reg;
                                end
                                enabled_reg  <= 1'b0;
                                on_prev_reg  <= 1'b0;
                                last_rpm_reg <= '0;
                            end
                            state_reg <= S_OUT;
                        end
                        default:
                        begin
                            state_reg <= enabled_reg ? S_CHK : S_OUT;
                        end
                    endcase
                end
                S_CHK:
                begin
                    if (period_due(now_reg, last_rpm_time_reg, rpm_period_reg))
                    begin
                        last_rpm_time_reg <= now_reg;
                        g60_reg     <= g60_next;
                        mh_reg      <= '0;
                        ml_reg      <= freq_reg;
                        seq_cnt_reg <= MUL_STEPS;
                        state_reg   <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_HRS;
                    end
                end
                S_MUL:
                begin
                    // shift-right multiplier: freq bits leave ml, product grows in mh
                    mh_reg <= mul_sum_next[QUO_W:1];
                    ml_reg <= {mul_sum_next[0], ml_reg[FREQ_W-1:1]};
                    if (seq_cnt_reg == 5'd1)
                    begin
                        rr_reg      <= '0;
                        seq_cnt_reg <= DIV_STEPS;
                        state_reg   <= S_DIV;
                    end
                    else
                    begin
                        seq_cnt_reg <= seq_cnt_reg - 5'd1;
                    end
                end
                S_DIV:
                begin
                    rr_reg <= rge_next ? rsub_next[POLE_W-1:0] : rt_next[POLE_W-1:0];
                    mh_reg <= {mh_reg[QUO_W-2:0], rge_next};
                    seq_cnt_reg <= seq_cnt_reg - 5'd1;
                    if (seq_cnt_reg == 5'd1)
                    begin
                        state_reg <= S_UPD1;
                    end
                end
                S_UPD1:
                begin
                    // adopt a value changed outside the block
                    if (stored_reg != persisted_reg)
                    begin
                        engine_ms_reg <= stored_reg;
                        persisted_reg <= stored_reg;
                    end
                    rpm_val_reg <= rpm_sat_next;
                    on_reg      <= rpm_sat_next > rpm_threshold_reg;
                    state_reg   <= S_UPD2;
                end
                S_UPD2:
                begin
                    // stored equals persisted here, so only the size of the gap matters
                    if (on_prev_reg && !on_reg && flush_ok_next)
                    begin
                        persisted_reg <= engine_ms_reg;
                        save_req_reg  <= 1'b1;
                        save_val_reg  <= engine_ms_reg;
                    end
                    on_prev_reg  <= on_reg;
                    last_rpm_reg <= rpm_val_reg;
                    rpm_rep_reg  <= 1'b1;
                    state_reg    <= on_reg ? S_ADD : S_HRS;
                end
                S_ADD:
                begin
                    engine_ms_reg <= add_next[MS_W] ? '1 : add_next[MS_W-1:0];
                    state_reg     <= S_SAVE;
                end
                S_SAVE:
                begin
                    if (period_due(now_reg, last_save_time_reg, save_period_reg))
                    begin
                        last_save_time_reg <= now_reg;
                        persisted_reg      <= engine_ms_reg;
                        save_req_reg       <= 1'b1;
                        save_val_reg       <= engine_ms_reg;
                    end
                    state_reg <= S_HRS;
                end
                S_HRS:
                begin
                    if (period_due(now_reg, last_hours_time_reg, hours_period_reg))
                    begin
                        last_hours_time_reg <= now_reg;
                        hrs_rep_reg         <= 1'b1;
                        state_reg           <= S_HDIV;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_HDIV:
                begin
                    if (dv_cnt_reg == '0)
                    begin
                        hrs_sec_reg <= dv_q_reg[SEC_W-1:0];
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg    <= 1'b1;
            out_rpm_reg      <= enabled_reg ? last_rpm_reg : '0;
            out_engine_reg   <= enabled_reg ? engine_ms_reg : '0;
            out_rpm_rep_reg  <= rpm_rep_reg;
            out_hrs_rep_reg  <= hrs_rep_reg;
            out_hrs_sec_reg  <= hrs_sec_reg;
            out_save_req_reg <= save_req_reg;
            out_save_val_reg <= save_val_reg;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign poll.ready            = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.rpm            = out_rpm_reg;
    assign result.engine_time_ms = out_engine_reg;
    assign result.rpm_report     = out_rpm_rep_reg;
    assign result.hours_report   = out_hrs_rep_reg;
    assign result.hours_seconds  = out_hrs_sec_reg;
    assign result.save_request   = out_save_req_reg;
    assign result.save_value_ms  = out_save_val_reg;

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !enabled_reg) |=> (result.rpm == '0 && result.engine_time_ms == '0))
        else $error("disabled block reported nonzero rpm or engine time");

    a_save_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.save_request) |-> (result.save_value_ms == '0))
        else $error("save value without save request");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD1) |-> (dv_cnt_reg == '0))
        else $error("rounded ms not ready at rpm update");

    a_hours_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.hours_report) |-> (result.hours_seconds == '0))
        else $error("hours seconds without hours report");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tehm_pkg::*;

    // code 3 is not in mode_t; the block handles it as a poll
    localparam logic [MODE_W-1:0] MODE_POLL_ALT = 2'd3;
    localparam logic [MS_W-1:0]   MS_MAX = {MS_W{1'b1}};
    localparam int SETTLE_CYCLES   = 150;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int MISMATCH_SHOWN  = 10;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 240;

    typedef struct {
        logic [RPM_W-1:0] rpm;
        logic [MS_W-1:0]  engine_time_ms;
        logic             rpm_report;
        logic             hours_report;
        logic [SEC_W-1:0] hours_seconds;
        logic             save_request;
        logic [MS_W-1:0]  save_value_ms;
    } meter_reading_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tehm_poll_if   poll_bus ();
    tehm_result_if result_bus ();

    tachometer_engine_hour_meter_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .poll    (poll_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted register contents
    logic [GAIN_W-1:0] cfg_gain         = RST_RPM_GAIN;
    logic [POLE_W-1:0] cfg_poles        = RST_POLE_COUNT;
    logic [RPM_W-1:0]  cfg_threshold    = RST_RPM_THRESHOLD;
    logic [TIME_W-1:0] cfg_rpm_period   = RST_RPM_PERIOD;
    logic [TIME_W-1:0] cfg_hours_period = RST_HOURS_PERIOD;
    logic [TIME_W-1:0] cfg_save_period  = RST_SAVE_PERIOD;
    logic [TIME_W-1:0] cfg_flush_min    = RST_FLUSH_MIN;

    // predicted meter state
    logic              meter_enabled  = 1'b0;
    logic              engine_running = 1'b0;
    logic [MS_W-1:0]   engine_ms      = '0;
    logic [MS_W-1:0]   persisted_ms   = '0;
    logic [TIME_W-1:0] rpm_mark_us    = '0;
    logic [TIME_W-1:0] hours_mark_us  = '0;
    logic [TIME_W-1:0] save_mark_us   = '0;
    logic [RPM_W-1:0]  shown_rpm      = '0;

    // stimulus side: wall clock and what persistence currently holds
    logic [TIME_W-1:0] clock_us = '0;
    logic [MS_W-1:0]   nvm_ms   = '0;
    bit                revving  = 1'b1;
    bit                no_idle  = 1'b0;

    meter_reading_t expected_readings[$];
    meter_reading_t oldest_reading;

    int cycle_count   = 0;
    int mismatches    = 0;
    int stall_left    = 0;
    int requests_sent = 0;
    int rpm_updates   = 0;
    int hours_reports = 0;
    int saves_seen    = 0;
    int cfg_writes    = 0;

    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // wrapping elapsed time; zero elapsed is never due
    function automatic logic interval_due(input logic [TIME_W-1:0] now,
                                          inout logic [TIME_W-1:0] mark,
                                          input logic [TIME_W-1:0] period,
                                          output logic [TIME_W-1:0] elapsed);
        elapsed = now - mark;
        if (elapsed >= period && elapsed != '0)
        begin
            mark = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic take_flush(input logic [MS_W-1:0] stored,
                                        input logic [TIME_W-1:0] min_ms);
        if (stored != persisted_ms || engine_ms <= persisted_ms)
            return 1'b0;
        if (engine_ms - persisted_ms < MS_W'(min_ms))
            return 1'b0;
        persisted_ms = engine_ms;
        return 1'b1;
    endfunction

    function automatic meter_reading_t predict_meter(input logic [MODE_W-1:0] mode,
                                                     input logic [TIME_W-1:0] now,
                                                     input logic [FREQ_W-1:0] freq,
                                                     input logic              fvalid,
                                                     input logic [MS_W-1:0]   stored);
        meter_reading_t    r;
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] unused_el;
        logic [FREQ_W-1:0] freq_used;
        logic [POLE_W-1:0] poles;
        logic [63:0]       rpm_full;
        logic [63:0]       add_ms;
        logic [64:0]       sum;
        logic              on;
        r = '{default: '0};
        if (mode == MODE_START)
        begin
            if (!meter_enabled)
            begin
                engine_ms     = stored;
                persisted_ms  = stored;
                shown_rpm     = '0;
                meter_enabled = 1'b1;
            end
        end
        else if (mode == MODE_STOP)
        begin
            if (meter_enabled)
            begin
                if (take_flush(stored, '0))
                begin
                    r.save_request  = 1'b1;
                    r.save_value_ms = engine_ms;
                end
                meter_enabled  = 1'b0;
                engine_running = 1'b0;
                shown_rpm      = '0;
            end
        end
        else if (meter_enabled)
        begin
            if (interval_due(now, rpm_mark_us, cfg_rpm_period, dt))
            begin
                freq_used = fvalid ? freq : '0;
                poles     = (cfg_poles == '0) ? POLE_W'(1) : cfg_poles;
                // Q8.16 gain times Q16.8 freq gives Q24.24
                rpm_full  = ((64'(cfg_gain) * 64'(freq_used) * 64'd60) / 64'(poles)) >> 24;
                if (rpm_full > 64'hFFFF)
                    rpm_full = 64'hFFFF;
                if (stored != persisted_ms)
                begin
                    engine_ms    = stored;
                    persisted_ms = stored;
                end
                on = rpm_full > 64'(cfg_threshold);
                if (engine_running && !on)
                begin
                    if (take_flush(stored, cfg_flush_min))
                    begin
                        r.save_request  = 1'b1;
                        r.save_value_ms = engine_ms;
                    end
                end
                engine_running = on;
                if (on)
                begin
                    add_ms    = (64'(dt) + 64'd500) / 64'd1000;
                    sum       = 65'(engine_ms) + 65'(add_ms);
                    engine_ms = (sum > 65'(MS_MAX)) ? MS_MAX : sum[MS_W-1:0];
                    if (interval_due(now, save_mark_us, cfg_save_period, unused_el))
                    begin
                        persisted_ms    = engine_ms;
                        r.save_request  = 1'b1;
                        r.save_value_ms = engine_ms;
                    end
                end
                shown_rpm    = rpm_full[RPM_W-1:0];
                r.rpm_report = 1'b1;
            end
            if (interval_due(now, hours_mark_us, cfg_hours_period, unused_el))
            begin
                r.hours_report  = 1'b1;
                r.hours_seconds = SEC_W'(engine_ms / 48'd1000);
            end
        end
        if (meter_enabled)
        begin
            r.rpm            = shown_rpm;
            r.engine_time_ms = engine_ms;
        end
        return r;
    endfunction

    // valid stays high across back-to-back requests; it drops only before a gap
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [TIME_W-1:0] now,
                                input logic [FREQ_W-1:0] freq,
                                input logic              fvalid,
                                input logic [MS_W-1:0]   stored);
        int             gap;
        meter_reading_t want;
        gap = pick_gap();
        if (gap > 0)
        begin
            poll_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_bus.valid      <= 1'b1;
        poll_bus.mode       <= mode;
        poll_bus.now_us     <= now;
        poll_bus.freq_hz    <= freq;
        poll_bus.freq_valid <= fvalid;
        poll_bus.stored_ms  <= stored;
        want = predict_meter(mode, now, freq, fvalid, stored);
        if (want.save_request)
            nvm_ms = want.save_value_ms;
        expected_readings.push_back(want);
        requests_sent++;
        rpm_updates   += int'(want.rpm_report);
        hours_reports += int'(want.hours_report);
        saves_seen    += int'(want.save_request);
        @(posedge clk);
        while (!poll_bus.ready)
            @(posedge clk);
    endtask

    task automatic wait_all_results();
        poll_bus.valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_RPM_GAIN:      cfg_gain         = value[GAIN_W-1:0];
            REG_POLE_COUNT:    cfg_poles        = value[POLE_W-1:0];
            REG_RPM_THRESHOLD: cfg_threshold    = value[RPM_W-1:0];
            REG_RPM_PERIOD:    cfg_rpm_period   = value;
            REG_HOURS_PERIOD:  cfg_hours_period = value;
            REG_SAVE_PERIOD:   cfg_save_period  = value;
            REG_FLUSH_MIN:     cfg_flush_min    = value;
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
                $display("mismatch on %s at cycle %0d: expected 0x%0h, got 0x%0h",
                         field, cycle_count, want, got);
        end
    endtask

    // reset values: 50 Hz on 12 poles is 250 rpm, just above the threshold
    task automatic test_reset_defaults();
        send_request(MODE_POLL, 32'd5000000, 24'd12800, 1'b1, 48'd0);
        send_request(MODE_STOP, 32'd5000000, 24'd12800, 1'b1, 48'd0);
        nvm_ms = 48'd7200000;
        send_request(MODE_START, 32'd0, 24'd0, 1'b0, nvm_ms);
        // second start while running is ignored
        send_request(MODE_START, 32'd0, 24'd0, 1'b0, 48'd99);
        send_request(MODE_POLL, 32'd0, 24'd12800, 1'b1, nvm_ms);
        send_request(MODE_POLL, 32'd1000000, 24'd12800, 1'b1, nvm_ms);
        send_request(MODE_POLL, 32'd2000400, 24'd12800, 1'b1, nvm_ms);
        // invalid reading drops to zero: engine stops, too little unsaved for a flush
        send_request(MODE_POLL, 32'd3000400, 24'd12800, 1'b0, nvm_ms);
        send_request(MODE_POLL_ALT, 32'd4000800, 24'd12800, 1'b1, nvm_ms);
        send_request(MODE_STOP, 32'd4000800, 24'd0, 1'b0, nvm_ms);
    endtask

    task automatic test_extreme_settings();
        wait_all_results();
        write_reg(REG_RPM_GAIN, 32'h00FF_FFFF);
        write_reg(REG_POLE_COUNT, 32'd1);
        write_reg(REG_RPM_THRESHOLD, 32'd0);
        write_reg(REG_RPM_PERIOD, 32'd1);
        write_reg(REG_HOURS_PERIOD, 32'd1);
        write_reg(REG_SAVE_PERIOD, 32'd1);
        write_reg(REG_FLUSH_MIN, 32'd0);
        nvm_ms = MS_MAX - 48'd1000;
        send_request(MODE_START, 32'd0, 24'd0, 1'b0, nvm_ms);
        // huge step: rpm and engine time both saturate
        send_request(MODE_POLL, 32'hFFFF_FFF0, 24'hFF_FFFF, 1'b1, nvm_ms);
        // time wraps past zero
        send_request(MODE_POLL, 32'h0000_0010, 24'd1, 1'b1, nvm_ms);
        // zero rpm is not above a zero threshold
        send_request(MODE_POLL, 32'h0000_0400, 24'd0, 1'b1, nvm_ms);
        // stored value changed outside the block
        nvm_ms = 48'h5555_5555_5555;
        send_request(MODE_POLL, 32'h0000_0800, 24'hAA_AAAA, 1'b1, nvm_ms);
        send_request(MODE_POLL, 32'h0000_9000, 24'h55_5555, 1'b1, nvm_ms);
        // stop flush refused while persistence disagrees
        send_request(MODE_STOP, 32'h0000_9000, 24'd0, 1'b0, 48'hAAAA_AAAA_AAAA);
        wait_all_results();
        write_reg(REG_RPM_GAIN, 32'd0);
        write_reg(REG_POLE_COUNT, 32'd0);
        write_reg(REG_RPM_THRESHOLD, 32'h0000_FFFF);
        write_reg(REG_RPM_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_HOURS_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_SAVE_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_FLUSH_MIN, 32'hFFFF_FFFF);
        send_request(MODE_START, 32'd0, 24'd0, 1'b0, nvm_ms);
        // only a full wrap of the timer reaches a max period
        send_request(MODE_POLL, rpm_mark_us - 32'd1, 24'hFF_FFFF, 1'b1, nvm_ms);
        send_request(MODE_POLL, rpm_mark_us, 24'hFF_FFFF, 1'b1, nvm_ms);
        wait_all_results();
        write_reg(REG_RPM_GAIN, 32'd65536);
        // zero poles count as one: 1 Hz gives 60 rpm
        send_request(MODE_POLL, rpm_mark_us - 32'd1, 24'd256, 1'b1, nvm_ms);
        send_request(MODE_STOP, 32'd0, 24'd0, 1'b0, nvm_ms);
    endtask

    task automatic test_random_runs();
        int                phase;
        int                n;
        int                roll;
        logic [FREQ_W-1:0] freq;
        logic              fv;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_all_results();
            no_idle = (phase == 2);
            write_reg(REG_RPM_GAIN, ($urandom_range(0, 4) == 0) ?
                      ($urandom() & 32'h00FF_FFFF) : $urandom_range(16384, 262144));
            write_reg(REG_POLE_COUNT, ($urandom_range(0, 4) == 0) ?
                      $urandom_range(1, 255) : $urandom_range(1, 32));
            write_reg(REG_RPM_THRESHOLD, ($urandom_range(0, 5) == 0) ?
                      $urandom_range(0, 65535) : $urandom_range(0, 3000));
            write_reg(REG_RPM_PERIOD, $urandom_range(1, 4000));
            write_reg(REG_HOURS_PERIOD, $urandom_range(1, 20000));
            write_reg(REG_SAVE_PERIOD, $urandom_range(1, 60000));
            write_reg(REG_FLUSH_MIN, ($urandom_range(0, 5) == 0) ?
                      $urandom() : $urandom_range(0, 30));
            clock_us = $urandom();
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    revving = !revving;
                if ($urandom_range(0, 6) == 0)
                begin
                    fv   = 1'b0;
                    freq = FREQ_W'($urandom());
                end
                else
                begin
                    fv   = 1'b1;
                    freq = revving ? FREQ_W'($urandom_range(24'h40_0000, 24'hFF_FFFF))
                                   : FREQ_W'($urandom_range(0, 24'h00_0FFF));
                end
                roll = $urandom_range(0, 99);
                if (!meter_enabled)
                begin
                    if (roll < 15)
                        nvm_ms = {16'($urandom()), $urandom()};
                    send_request(MODE_START, clock_us, freq, fv, nvm_ms);
                end
                else if (roll < 3)
                    send_request(MODE_STOP, clock_us, freq, fv, nvm_ms);
                else if (roll < 7)
                    send_request(MODE_W'($urandom_range(0, 3)), $urandom(),
                                 FREQ_W'($urandom()), 1'($urandom()),
                                 {16'($urandom()), $urandom()});
                else
                begin
                    if (roll < 10)
                        nvm_ms = {16'($urandom()), $urandom()};
                    clock_us += (roll < 13) ? $urandom()
                                            : $urandom_range(0, 2 * cfg_rpm_period);
                    send_request(($urandom_range(0, 19) == 0) ? MODE_POLL_ALT : MODE_POLL,
                                 clock_us, freq, fv, nvm_ms);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // result side: random stalls on ready, in-order compare against predictions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MISMATCH_SHOWN)
                        $display("result with nothing expected at cycle %0d", cycle_count);
                end
                else
                begin
                    oldest_reading = expected_readings.pop_front();
                    compare_field("rpm", 64'(oldest_reading.rpm), 64'(result_bus.rpm));
                    compare_field("engine_time_ms", 64'(oldest_reading.engine_time_ms),
                                  64'(result_bus.engine_time_ms));
                    compare_field("rpm_report", 64'(oldest_reading.rpm_report),
                                  64'(result_bus.rpm_report));
                    compare_field("hours_report", 64'(oldest_reading.hours_report),
                                  64'(result_bus.hours_report));
                    compare_field("hours_seconds", 64'(oldest_reading.hours_seconds),
                                  64'(result_bus.hours_seconds));
                    compare_field("save_request", 64'(oldest_reading.save_request),
                                  64'(result_bus.save_request));
                    compare_field("save_value_ms", 64'(oldest_reading.save_value_ms),
                                  64'(result_bus.save_value_ms));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
        else
        begin
            result_bus.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_readings.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        poll_bus.valid      <= 1'b0;
        poll_bus.mode       <= '0;
        poll_bus.now_us     <= '0;
        poll_bus.freq_hz    <= '0;
        poll_bus.freq_valid <= 1'b0;
        poll_bus.stored_ms  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extreme_settings();
        test_random_runs();
        wait_all_results();

        $display("%0d requests: %0d rpm updates, %0d hours reports, %0d saves",
                 requests_sent, rpm_updates, hours_reports, saves_seen);
        $display("%0d register writes over reset, extreme and %0d random settings",
                 cfg_writes, RANDOM_PHASES);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
